>>> rtl/core/chbs_pkg.sv
// Package for the consistent-hash backend selector.
// Holds request/response structs, codes, table sizes and the prime mask.
// No dependencies.
package chbs_pkg;

  localparam int MAX_ROWS     = 256;
  localparam int MAX_BACKENDS = 32;
  localparam int ROW_W        = $clog2(MAX_ROWS);
  localparam int RANK_W       = $clog2(MAX_BACKENDS);
  localparam int HEIGHT_W     = 9;
  localparam int COUNT_W      = 6;
  localparam int HASH_W       = 32;
  localparam int CFG_W        = 9;
  localparam logic [8:0] PERM_OFFSET_MUL = 9'd31;

  typedef enum logic [1:0] {
    REQ_BUILD  = 2'd0,
    REQ_ACTIVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADCFG   = 2'd1,
    ST_NOTBUILT = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  typedef enum logic {
    CFG_HEIGHT = 1'b0,
    CFG_COUNT  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [HASH_W-1:0] flow_hash;
    logic [4:0]        backend_sel;
    logic              make_active;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [4:0] backend_id;
    logic [1:0] status;
  } resp_t;

  // sieve: strike every multiple of each d from d*d upward
  function automatic logic [255:0] prime_mask();
    logic [255:0] m;
    m    = '1;
    m[0] = 1'b0;
    m[1] = 1'b0;
    for (int d = 2; d * d < 256; d++) begin
      for (int j = d * d; j < 256; j += d) m[j] = 1'b0;
    end
    return m;
  endfunction

  localparam logic [255:0] PRIME_MASK = prime_mask();

endpackage

>>> rtl/core/chbs_mod_unit.sv
// Serial remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on chbs_pkg.
module chbs_mod_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [chbs_pkg::HASH_W-1:0]     dividend,
  input  logic [chbs_pkg::HEIGHT_W-1:0]   divisor,
  output logic                            done,
  output logic [chbs_pkg::HEIGHT_W-1:0]   rem
);
  import chbs_pkg::*;

  logic [HASH_W-1:0]         q;
  logic [$clog2(HASH_W+1)-1:0] cnt;
  logic [HEIGHT_W:0]         shifted;

  assign shifted = {rem, q[HASH_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q   <= dividend;
        rem <= '0;
        cnt <= ($clog2(HASH_W+1))'(HASH_W);
      end else if (cnt != '0) begin
        q   <= {q[HASH_W-2:0], 1'b0};
        if (shifted >= {1'b0, divisor}) rem <= HEIGHT_W'(shifted - {1'b0, divisor});
        else rem <= HEIGHT_W'(shifted);
        cnt <= cnt - 1'b1;
        if (cnt == ($clog2(HASH_W+1))'(1)) done <= 1'b1;
      end
    end
  end
endmodule

>>> rtl/core/consistent_hash_backend_selector_core.sv
// Consistent-hash backend selector top level: control, preference table
// memory and per-row fill-count memory. Depends on chbs_pkg, chbs_mod_unit.
//
//  channel  | signals                          | direction
//  request  | req_valid, req_stall, req        | in
//  response | resp_valid, resp_stall, resp     | out
//  config   | cfg_we, cfg_index, cfg_data      | in
//
// Activity, unused code and rejected requests go from accept straight to
// present. Lookup: the remainder unit, then the rank walk (one table read
// per rank, one memory port), then present. Build: fill-count clear over
// height rows, reduction of 31 mod height, one offset step per backend,
// then the fill, where every entry takes a read then a write of the row
// fill-count memory.
// Reset is synchronous; no clearing pass. A stalled response holds one
// result while the next request is already taken.
module consistent_hash_backend_selector_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  chbs_pkg::req_t    req,
  output logic              resp_valid,
  input  logic              resp_stall,
  output chbs_pkg::resp_t   resp,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [chbs_pkg::CFG_W-1:0] cfg_data
);
  import chbs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CLR  = 9'b000000010,
    S_M31  = 9'b000000100,
    S_INIT = 9'b000001000,
    S_BRD  = 9'b000010000,
    S_BWR  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_LOOK = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t               state;
  logic [HEIGHT_W-1:0]  table_height;
  logic [COUNT_W-1:0]   backend_count;
  logic [31:0]          active_mask;
  logic                 table_built;
  resp_t                result;
  logic                 cfg_ok;

  logic [RANK_W-1:0]    cnt_mem [MAX_ROWS];
  logic [4:0]           tbl_mem [MAX_ROWS*MAX_BACKENDS];
  logic [RANK_W-1:0]    cnt_q;
  logic [4:0]           tbl_q;

  logic [ROW_W-1:0]     cur_r [MAX_BACKENDS];
  logic [RANK_W-1:0]    bidx;
  logic [HEIGHT_W-1:0]  pos;
  logic [HEIGHT_W-1:0]  clr_r;
  logic [HEIGHT_W-1:0]  c31;
  logic [ROW_W-1:0]     off;
  logic [ROW_W-1:0]     row;
  logic [COUNT_W-1:0]   k;
  logic                 rd_valid;

  logic                 div_start;
  logic                 div_done;
  logic [HEIGHT_W-1:0]  div_rem;

  logic                 accept;
  logic                 b_last;
  logic [HEIGHT_W-1:0]  step_sum;
  logic [HEIGHT_W:0]    off_sum;
  logic                 hit;
  logic                 slot_free;
  logic                 resp_load;
  logic                 build_end;
  logic [1:0]           idle_status;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign slot_free = !resp_valid || !resp_stall;
  assign resp_load = (state == S_FIN) && slot_free;

  assign cfg_ok = (table_height >= HEIGHT_W'(3)) && (table_height < HEIGHT_W'(MAX_ROWS))
               && (backend_count >= COUNT_W'(1))
               && (backend_count <= COUNT_W'(MAX_BACKENDS))
               && ({3'b0, backend_count} < table_height)
               && PRIME_MASK[table_height[7:0]];

  assign b_last    = ({1'b0, bidx} == backend_count - 1'b1);
  assign build_end = (state == S_BWR) && b_last && (pos == table_height - 1'b1);
  assign step_sum  = {1'b0, cur_r[bidx]} + {4'b0, bidx} + HEIGHT_W'(1);
  assign off_sum   = {2'b0, off} + {1'b0, c31};
  assign hit       = rd_valid && active_mask[tbl_q];
  assign div_start = accept && (req.req_type == REQ_LOOKUP) && table_built && cfg_ok;

  always_comb begin
    idle_status = ST_OK;
    if (req.req_type == REQ_BUILD && !cfg_ok) idle_status = ST_BADCFG;
    else if (req.req_type == REQ_LOOKUP && !(table_built && cfg_ok)) idle_status = ST_NOTBUILT;
  end

  chbs_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.flow_hash),
    .divisor  (table_height),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (state == S_CLR) cnt_mem[clr_r[ROW_W-1:0]] <= '0;
    else if (state == S_BWR) cnt_mem[cur_r[bidx]] <= cnt_q + 1'b1;
    cnt_q <= cnt_mem[cur_r[bidx]];
  end

  always_ff @(posedge clk) begin
    if (state == S_BWR) tbl_mem[{cur_r[bidx], cnt_q}] <= bidx;
    tbl_q <= tbl_mem[{row, k[RANK_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (state == S_INIT) cur_r[bidx] <= off;
    else if (state == S_BWR) begin
      if (step_sum >= table_height) cur_r[bidx] <= ROW_W'(step_sum - table_height);
      else cur_r[bidx] <= ROW_W'(step_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      table_height  <= HEIGHT_W'(251);
      backend_count <= COUNT_W'(32);
      active_mask   <= '0;
      table_built   <= 1'b0;
      resp_valid    <= 1'b0;
    end else begin
      if (resp_load) resp_valid <= 1'b1;
      else if (!resp_stall) resp_valid <= 1'b0;
      if (cfg_we || (accept && req.req_type == REQ_BUILD)) table_built <= 1'b0;
      else if (build_end) table_built <= 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HEIGHT: table_height  <= cfg_data[HEIGHT_W-1:0];
          CFG_COUNT:  backend_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            result <= '{found: 1'b0, backend_id: 5'd0, status: idle_status};
            case (req.req_type)
              REQ_BUILD: begin
                if (cfg_ok) begin
                  clr_r <= '0;
                  c31   <= PERM_OFFSET_MUL;
                  state <= S_CLR;
                end else begin
                  state <= S_FIN;
                end
              end
              REQ_ACTIVE: begin
                active_mask[req.backend_sel] <= req.make_active;
                state <= S_FIN;
              end
              REQ_LOOKUP: begin
                if (table_built && cfg_ok) state <= S_DIV;
                else state <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == table_height - 1'b1) state <= S_M31;
        end
        S_M31: begin
          if (c31 >= table_height) c31 <= c31 - table_height;
          else begin
            bidx  <= '0;
            off   <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if (off_sum >= {1'b0, table_height}) off <= ROW_W'(off_sum - {1'b0, table_height});
          else off <= ROW_W'(off_sum);
          if (b_last) begin
            bidx  <= '0;
            pos   <= '0;
            state <= S_BRD;
          end else begin
            bidx <= bidx + 1'b1;
          end
        end
        S_BRD: state <= S_BWR;
        S_BWR: begin
          if (b_last) begin
            bidx <= '0;
            if (build_end) begin
              state <= S_FIN;
            end else begin
              pos   <= pos + 1'b1;
              state <= S_BRD;
            end
          end else begin
            bidx  <= bidx + 1'b1;
            state <= S_BRD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            row      <= div_rem[ROW_W-1:0];
            k        <= '0;
            rd_valid <= 1'b0;
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (hit) begin
            result.found      <= 1'b1;
            result.backend_id <= tbl_q;
            state             <= S_FIN;
          end else if (k == backend_count) begin
            state <= S_FIN;
          end else begin
            k        <= k + 1'b1;
            rd_valid <= 1'b1;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            resp  <= result;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
